FILE: design/pvmm_pkg.sv
// ----------------------------------------------------------------------------
// pvmm_pkg
// Beat types and fixed constants for the pose view-matrix row multiplier.
// ----------------------------------------------------------------------------
package pvmm_pkg;

    localparam int ELEM_W     = 32;
    localparam int ROW_W      = 2;
    localparam int QBITS      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z  = 3'd6;

    localparam logic [ELEM_W-1:0] QUAT_ONE = 32'h4000_0000;

    typedef struct packed {
        logic        [ROW_W-1:0]  row_index;
        logic signed [ELEM_W-1:0] cam_c0;
        logic signed [ELEM_W-1:0] cam_c1;
        logic signed [ELEM_W-1:0] cam_c2;
        logic signed [ELEM_W-1:0] cam_c3;
    } pvmm_in_t;

    typedef struct packed {
        logic        [ROW_W-1:0]  out_row;
        logic signed [ELEM_W-1:0] out_c0;
        logic signed [ELEM_W-1:0] out_c1;
        logic signed [ELEM_W-1:0] out_c2;
        logic signed [ELEM_W-1:0] out_c3;
        logic                     saturated;
    } pvmm_out_t;

endpackage

FILE: design/pose_view_matrix_multiply.sv
// ----------------------------------------------------------------------------
// pose_view_matrix_multiply
// Multiplies camera matrix rows by the view matrix of a configured headset pose.
// ----------------------------------------------------------------------------
// One row beat enters per clock while cam_stall is low; the row
// path is six register stages (input, align, 9 products, row sums, translation
// products, combine and saturate). The rotation and translation terms are
// derived from the pose registers by a free-running four-stage chain that
// stays ahead of the rows, so a row may follow a pose write in the next cycle.
// Pose registers must only be written while no row is in flight.
module pose_view_matrix_multiply
    import pvmm_pkg::*;
#(
    parameter int DATA_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cam_valid,
    output logic                  cam_stall,
    input  pvmm_in_t              cam_beat,
    output logic                  view_valid,
    input  logic                  view_stall,
    output pvmm_out_t             view_beat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QP_W   = 36;
    localparam int RAW_W  = 40;
    localparam int TP_W   = 65;
    localparam int TS_W   = 66;
    localparam int TJ_W   = 38;
    localparam int TH_W   = TJ_W - FRAC_BITS;
    localparam int CP_W   = 64;
    localparam int ROT_W  = 36;
    localparam int MH_W   = ELEM_W + TH_W;
    localparam int ML_W   = ELEM_W + FRAC_BITS + 1;
    localparam int ACC_W  = 72;

    localparam logic signed [RAW_W-1:0] ROT_ONE  = RAW_W'(64'sd1 <<< QBITS);
    localparam logic signed [RAW_W-1:0] ROT_MAX  = RAW_W'((64'sd1 <<< 31) - 1);
    localparam logic signed [RAW_W-1:0] ROT_MIN  = -ROT_MAX - RAW_W'(1);
    localparam logic signed [ACC_W-1:0] DAT_MAX  = (ACC_W'(1) <<< (DATA_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] DAT_MIN  = -DAT_MAX - ACC_W'(1);
    localparam logic signed [ML_W-1:0]  F_HALF   = ML_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [CP_W+1:0]  Q_HALF66 = (CP_W+2)'(1) <<< (QBITS - 1);
    localparam logic signed [TS_W-1:0]  Q_HALFTS = TS_W'(1) <<< (QBITS - 1);

    function automatic logic signed [QP_W-1:0] qmul(input logic signed [32:0] a,
                                                    input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + 66'sd536870912;
        return p[65:QBITS];
    endfunction

    // ---------------- configuration registers ----------------
    logic [ELEM_W-1:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;
    logic [ELEM_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= QUAT_ONE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUAT_X: quat_x_reg <= cfg_data;
                REG_QUAT_Y: quat_y_reg <= cfg_data;
                REG_QUAT_Z: quat_z_reg <= cfg_data;
                REG_QUAT_W: quat_w_reg <= cfg_data;
                REG_POS_X:  pos_x_reg  <= cfg_data;
                REG_POS_Y:  pos_y_reg  <= cfg_data;
                REG_POS_Z:  pos_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pose chain, stage 1: quaternion products ----------------
    logic signed [32:0] qx, qy, qz, qw;
    logic signed [QP_W-1:0] xx_next, yy_next, zz_next, xy_next, xz_next, yz_next;
    logic signed [QP_W-1:0] wx_next, wy_next, wz_next;
    logic signed [QP_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [QP_W-1:0] wx_reg, wy_reg, wz_reg;

    always_comb
    begin
        // handedness flip on x and y
        qx = -$signed({quat_x_reg[ELEM_W-1], quat_x_reg});
        qy = -$signed({quat_y_reg[ELEM_W-1], quat_y_reg});
        qz = $signed({quat_z_reg[ELEM_W-1], quat_z_reg});
        qw = $signed({quat_w_reg[ELEM_W-1], quat_w_reg});
        xx_next = qmul(qx, qx);
        yy_next = qmul(qy, qy);
        zz_next = qmul(qz, qz);
        xy_next = qmul(qx, qy);
        xz_next = qmul(qx, qz);
        yz_next = qmul(qy, qz);
        wx_next = qmul(qw, qx);
        wy_next = qmul(qw, qy);
        wz_next = qmul(qw, qz);
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        zz_reg <= zz_next;
        xy_reg <= xy_next;
        xz_reg <= xz_next;
        yz_reg <= yz_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;
        wz_reg <= wz_next;
    end

    // ---------------- pose chain, stage 2: rotation matrix ----------------
    logic signed [RAW_W-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
    logic signed [RAW_W-1:0] rraw [9];
    logic signed [ELEM_W-1:0] r_next [9];
    logic signed [ELEM_W-1:0] r_reg  [9];
    logic rsat_next, rsat_reg;

    always_comb
    begin
        exx = xx_reg;
        eyy = yy_reg;
        ezz = zz_reg;
        exy = xy_reg;
        exz = xz_reg;
        eyz = yz_reg;
        ewx = wx_reg;
        ewy = wy_reg;
        ewz = wz_reg;
        rraw[0] = ROT_ONE - ((eyy + ezz) <<< 1);
        rraw[1] = (exy + ewz) <<< 1;
        rraw[2] = (exz - ewy) <<< 1;
        rraw[3] = (exy - ewz) <<< 1;
        rraw[4] = ROT_ONE - ((exx + ezz) <<< 1);
        rraw[5] = (eyz + ewx) <<< 1;
        rraw[6] = (exz + ewy) <<< 1;
        rraw[7] = (eyz - ewx) <<< 1;
        rraw[8] = ROT_ONE - ((exx + eyy) <<< 1);
        rsat_next = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            if (rraw[i] > ROT_MAX)
            begin
                r_next[i] = ROT_MAX[ELEM_W-1:0];
                rsat_next = 1'b1;
            end
            else if (rraw[i] < ROT_MIN)
            begin
                r_next[i] = ROT_MIN[ELEM_W-1:0];
                rsat_next = 1'b1;
            end
            else
            begin
                r_next[i] = rraw[i][ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            r_reg[i] <= r_next[i];
        end
        rsat_reg <= rsat_next;
    end

    // ---------------- pose chain, stage 3: translation products ----------------
    logic signed [32:0] tv [3];
    logic signed [TP_W-1:0] tp_next [9];
    logic signed [TP_W-1:0] tp_reg  [9];

    always_comb
    begin
        tv[0] = $signed({pos_x_reg[ELEM_W-1], pos_x_reg});
        tv[1] = $signed({pos_y_reg[ELEM_W-1], pos_y_reg});
        tv[2] = -$signed({pos_z_reg[ELEM_W-1], pos_z_reg});
        for (int i = 0; i < 9; i++)
        begin
            tp_next[i] = TP_W'(tv[i % 3] * r_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            tp_reg[i] <= tp_next[i];
        end
    end

    // ---------------- pose chain, stage 4: last row of view matrix ----------------
    logic signed [TS_W-1:0] tsum [3];
    logic signed [TJ_W-1:0] tj_next [3];
    logic signed [TJ_W-1:0] tj_reg  [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tsum[j] = TS_W'(tp_reg[3*j]) + TS_W'(tp_reg[3*j+1]) + TS_W'(tp_reg[3*j+2])
                      + Q_HALFTS;
            tj_next[j] = -TJ_W'(tsum[j] >>> QBITS);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            tj_reg[j] <= tj_next[j];
        end
    end

    // ---------------- row pipeline ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || !view_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign cam_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= cam_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // stage 1: input beat
    pvmm_in_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg <= cam_beat;
    end

    // stage 2: align, clip column 3
    logic signed [ACC_W-1:0] c3_ext;
    logic signed [ELEM_W-1:0] c3o_next;
    logic c3sat_next;
    pvmm_in_t s2_reg;
    logic signed [ELEM_W-1:0] s2_c3o_reg;
    logic s2_c3sat_reg;

    always_comb
    begin
        c3_ext = s1_reg.cam_c3;
        if (c3_ext > DAT_MAX)
        begin
            c3o_next   = DAT_MAX[ELEM_W-1:0];
            c3sat_next = 1'b1;
        end
        else if (c3_ext < DAT_MIN)
        begin
            c3o_next   = DAT_MIN[ELEM_W-1:0];
            c3sat_next = 1'b1;
        end
        else
        begin
            c3o_next   = s1_reg.cam_c3;
            c3sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_reg       <= s1_reg;
            s2_c3o_reg   <= c3o_next;
            s2_c3sat_reg <= c3sat_next;
        end
    end

    // stage 3: rotation products
    logic signed [ELEM_W-1:0] cv [3];
    logic signed [CP_W-1:0] cp_next [9];
    logic signed [CP_W-1:0] cp_reg  [9];
    logic [ROW_W-1:0] s3_row_reg;
    logic signed [ELEM_W-1:0] s3_c3_reg, s3_c3o_reg;
    logic s3_c3sat_reg;

    always_comb
    begin
        cv[0] = s2_reg.cam_c0;
        cv[1] = s2_reg.cam_c1;
        cv[2] = s2_reg.cam_c2;
        for (int i = 0; i < 9; i++)
        begin
            cp_next[i] = CP_W'(cv[i % 3] * r_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            for (int i = 0; i < 9; i++)
            begin
                cp_reg[i] <= cp_next[i];
            end
            s3_row_reg   <= s2_reg.row_index;
            s3_c3_reg    <= s2_reg.cam_c3;
            s3_c3o_reg   <= s2_c3o_reg;
            s3_c3sat_reg <= s2_c3sat_reg;
        end
    end

    // stage 4: rotation row sums, rounded from Q.(F+30)
    logic signed [CP_W+1:0] csum [3];
    logic signed [ROT_W-1:0] rot_next [3];
    logic signed [ROT_W-1:0] rot4_reg [3];
    logic [ROW_W-1:0] s4_row_reg;
    logic signed [ELEM_W-1:0] s4_c3_reg, s4_c3o_reg;
    logic s4_c3sat_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            csum[j] = (CP_W+2)'(cp_reg[3*j]) + (CP_W+2)'(cp_reg[3*j+1])
                      + (CP_W+2)'(cp_reg[3*j+2]) + Q_HALF66;
            rot_next[j] = ROT_W'(csum[j] >>> QBITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rot4_reg[j] <= rot_next[j];
            end
            s4_row_reg   <= s3_row_reg;
            s4_c3_reg    <= s3_c3_reg;
            s4_c3o_reg   <= s3_c3o_reg;
            s4_c3sat_reg <= s3_c3sat_reg;
        end
    end

    // stage 5: translation products, split high and low around the binary point
    logic signed [TH_W-1:0] th [3];
    logic signed [FRAC_BITS:0] tl [3];
    logic signed [MH_W-1:0] mh_next [3];
    logic signed [ML_W-1:0] ml_next [3];
    logic signed [MH_W-1:0] mh_reg [3];
    logic signed [ML_W-1:0] ml_reg [3];
    logic signed [ROT_W-1:0] rot5_reg [3];
    logic [ROW_W-1:0] s5_row_reg;
    logic signed [ELEM_W-1:0] s5_c3o_reg;
    logic s5_c3sat_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            th[j] = tj_reg[j][TJ_W-1:FRAC_BITS];
            tl[j] = $signed({1'b0, tj_reg[j][FRAC_BITS-1:0]});
            mh_next[j] = MH_W'(s4_c3_reg * th[j]);
            ml_next[j] = ML_W'(s4_c3_reg * tl[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mh_reg[j]   <= mh_next[j];
                ml_reg[j]   <= ml_next[j];
                rot5_reg[j] <= rot4_reg[j];
            end
            s5_row_reg   <= s4_row_reg;
            s5_c3o_reg   <= s4_c3o_reg;
            s5_c3sat_reg <= s4_c3sat_reg;
        end
    end

    // stage 6: combine, saturate, output register
    logic signed [ML_W-1:0] mlr [3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [ELEM_W-1:0] oc_next [3];
    logic sat_next;
    pvmm_out_t out_next;
    pvmm_out_t out_reg;

    always_comb
    begin
        sat_next = s5_c3sat_reg | rsat_reg;
        for (int j = 0; j < 3; j++)
        begin
            mlr[j] = (ml_reg[j] + F_HALF) >>> FRAC_BITS;
            acc[j] = ACC_W'(rot5_reg[j]) + ACC_W'(mh_reg[j]) + ACC_W'(mlr[j]);
            if (acc[j] > DAT_MAX)
            begin
                oc_next[j] = DAT_MAX[ELEM_W-1:0];
                sat_next   = 1'b1;
            end
            else if (acc[j] < DAT_MIN)
            begin
                oc_next[j] = DAT_MIN[ELEM_W-1:0];
                sat_next   = 1'b1;
            end
            else
            begin
                oc_next[j] = acc[j][ELEM_W-1:0];
            end
        end
        out_next.out_row   = s5_row_reg;
        out_next.out_c0    = oc_next[0];
        out_next.out_c1    = oc_next[1];
        out_next.out_c2    = oc_next[2];
        out_next.out_c3    = s5_c3o_reg;
        out_next.saturated = sat_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6) out_reg <= out_next;
    end

    assign view_valid = v6_reg;
    assign view_beat  = out_reg;

endmodule
